// ----- design/gbb_pkg.sv -----
// ----------------------------------------------------------------------------
// gbb_pkg
// shared types and constants of the glyph bitmap blitter
// ----------------------------------------------------------------------------
package gbb_pkg;

    // item command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BLIT = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_GLYPH_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_GLYPH_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_GLYPH_BYTES   = 3'd2;
    localparam logic [2:0] CFG_GLYPH_COUNT   = 3'd3;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_LINE_PITCH    = 3'd6;

    // register reset values
    localparam logic [5:0]  RST_GLYPH_WIDTH   = 6'd8;
    localparam logic [5:0]  RST_GLYPH_HEIGHT  = 6'd16;
    localparam logic [7:0]  RST_GLYPH_BYTES   = 8'd16;
    localparam logic [15:0] RST_GLYPH_COUNT   = 16'd256;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [13:0] RST_LINE_PITCH    = 14'd2560;

    // font store is split into byte banks so one glyph row is read per cycle
    localparam int NUM_BANKS    = 8;
    // widest store address for any allowed store size
    localparam int STORE_AW_MAX = 16;
    // bit index inside one glyph, up to 32 rows of 32 pixels
    localparam int IDX_W        = 11;

    typedef struct packed {
        logic               cmd;
        logic [13:0]        store_address;
        logic [7:0]         store_byte;
        logic [31:0]        glyph_code;
        logic signed [15:0] cell_column;
        logic signed [15:0] cell_row;
    } t_in_word;

    typedef struct packed {
        logic [25:0] row_offset;
        logic [31:0] row_pixels;
        logic        last_row;
    } t_out_word;

    typedef struct packed {
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [7:0]  glyph_bytes;
        logic [15:0] glyph_count;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [13:0] line_pitch;
    } t_cfg;

    // item leaving the setup pipeline
    typedef struct packed {
        logic                    valid;
        logic                    cmd;
        logic                    drop;
        logic [STORE_AW_MAX-1:0] addr;
        logic [7:0]              data;
        logic [STORE_AW_MAX-1:0] base;
        logic [25:0]             offset;
        logic [5:0]              w;
        logic [5:0]              h;
    } t_setup_word;

    // one glyph row read request
    typedef struct packed {
        logic                    valid;
        logic [STORE_AW_MAX-1:0] a0;
        logic [2:0]              bit_off;
        logic [5:0]              w;
        logic [25:0]             offset;
        logic                    last;
    } t_fetch_req;

    typedef struct packed {
        logic                    en;
        logic [STORE_AW_MAX-1:0] addr;
        logic [7:0]              data;
    } t_store_wr;

    function automatic logic [5:0] clamp_side(input logic [5:0] v, input logic [5:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ----- design/gbb_setup.sv -----
// ----------------------------------------------------------------------------
// gbb_setup
// four stage front end: glyph select, products, cell test, first row offset
// ----------------------------------------------------------------------------
module gbb_setup #(
    parameter int MAX_GLYPH_SIDE = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  gbb_pkg::t_in_word   i_item,
    input  gbb_pkg::t_cfg       i_cfg,
    input  logic                i_ready,
    output logic                busy,
    output gbb_pkg::t_setup_word o_word
);
    import gbb_pkg::*;

    logic w_adv;

    // stage 1
    logic                    r_s1_valid;
    logic                    r_s1_cmd;
    logic [STORE_AW_MAX-1:0] r_s1_addr;
    logic [7:0]              r_s1_data;
    logic [15:0]             r_s1_glyph;
    logic                    r_s1_neg;
    logic [14:0]             r_s1_col;
    logic [14:0]             r_s1_row;
    logic [5:0]              r_s1_w;
    logic [5:0]              r_s1_h;
    // stage 2
    logic                    r_s2_valid;
    logic                    r_s2_cmd;
    logic [STORE_AW_MAX-1:0] r_s2_addr;
    logic [7:0]              r_s2_data;
    logic                    r_s2_neg;
    logic [21:0]             r_s2_cw1;
    logic [21:0]             r_s2_rh1;
    logic [11:0]             r_s2_colw;
    logic [11:0]             r_s2_rowh;
    logic [STORE_AW_MAX-1:0] r_s2_base;
    logic [5:0]              r_s2_w;
    logic [5:0]              r_s2_h;
    // stage 3
    logic                    r_s3_valid;
    logic                    r_s3_cmd;
    logic [STORE_AW_MAX-1:0] r_s3_addr;
    logic [7:0]              r_s3_data;
    logic                    r_s3_drop;
    logic [25:0]             r_s3_prod;
    logic [13:0]             r_s3_colw4;
    logic [STORE_AW_MAX-1:0] r_s3_base;
    logic [5:0]              r_s3_w;
    logic [5:0]              r_s3_h;
    // stage 4
    logic                    r_s4_valid;
    logic                    r_s4_cmd;
    logic [STORE_AW_MAX-1:0] r_s4_addr;
    logic [7:0]              r_s4_data;
    logic                    r_s4_drop;
    logic [25:0]             r_s4_offset;
    logic [STORE_AW_MAX-1:0] r_s4_base;
    logic [5:0]              r_s4_w;
    logic [5:0]              r_s4_h;

    logic [23:0] w_base_full;
    logic [20:0] w_colw_full;
    logic [20:0] w_rowh_full;

    // whole front end moves as one while the last stage can be handed on
    assign w_adv = !r_s4_valid || i_ready;
    assign busy  = !w_adv;

    assign w_base_full = 24'(i_cfg.glyph_bytes) * 24'(r_s1_glyph);
    assign w_colw_full = 21'(r_s1_col) * 21'(r_s1_w);
    assign w_rowh_full = 21'(r_s1_row) * 21'(r_s1_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= start;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 1: register the item, pick the glyph, clamp the sides
            r_s1_cmd   <= i_item.cmd;
            r_s1_addr  <= STORE_AW_MAX'(i_item.store_address);
            r_s1_data  <= i_item.store_byte;
            r_s1_glyph <= (i_item.glyph_code < 32'(i_cfg.glyph_count)) ?
                          i_item.glyph_code[15:0] : 16'd0;
            r_s1_neg   <= i_item.cell_column[15] | i_item.cell_row[15];
            r_s1_col   <= i_item.cell_column[14:0];
            r_s1_row   <= i_item.cell_row[14:0];
            r_s1_w     <= clamp_side(i_cfg.glyph_width, 6'(MAX_GLYPH_SIDE));
            r_s1_h     <= clamp_side(i_cfg.glyph_height, 6'(MAX_GLYPH_SIDE));

            // stage 2: products
            r_s2_cmd  <= r_s1_cmd;
            r_s2_addr <= r_s1_addr;
            r_s2_data <= r_s1_data;
            r_s2_neg  <= r_s1_neg;
            r_s2_cw1  <= 22'(16'(r_s1_col) + 16'd1) * 22'(r_s1_w);
            r_s2_rh1  <= 22'(16'(r_s1_row) + 16'd1) * 22'(r_s1_h);
            // cell passes only when these stay below 4095
            r_s2_colw <= w_colw_full[11:0];
            r_s2_rowh <= w_rowh_full[11:0];
            r_s2_base <= w_base_full[STORE_AW_MAX-1:0];
            r_s2_w    <= r_s1_w;
            r_s2_h    <= r_s1_h;

            // stage 3: cell test and pitch product
            r_s3_cmd   <= r_s2_cmd;
            r_s3_addr  <= r_s2_addr;
            r_s3_data  <= r_s2_data;
            r_s3_drop  <= r_s2_neg || (r_s2_h == 6'd0) ||
                          (r_s2_cw1 >= 22'(i_cfg.screen_width)) ||
                          (r_s2_rh1 >= 22'(i_cfg.screen_height));
            r_s3_prod  <= 26'(i_cfg.line_pitch) * 26'(r_s2_rowh);
            r_s3_colw4 <= {r_s2_colw, 2'b00};
            r_s3_base  <= r_s2_base;
            r_s3_w     <= r_s2_w;
            r_s3_h     <= r_s2_h;

            // stage 4: first row offset
            r_s4_cmd    <= r_s3_cmd;
            r_s4_addr   <= r_s3_addr;
            r_s4_data   <= r_s3_data;
            r_s4_drop   <= r_s3_drop;
            r_s4_offset <= r_s3_prod + 26'(r_s3_colw4);
            r_s4_base   <= r_s3_base;
            r_s4_w      <= r_s3_w;
            r_s4_h      <= r_s3_h;
        end
    end

    assign o_word = '{
        valid:  r_s4_valid,
        cmd:    r_s4_cmd,
        drop:   r_s4_drop,
        addr:   r_s4_addr,
        data:   r_s4_data,
        base:   r_s4_base,
        offset: r_s4_offset,
        w:      r_s4_w,
        h:      r_s4_h
    };

endmodule

// ----- design/gbb_rowgen.sv -----
// ----------------------------------------------------------------------------
// gbb_rowgen
// row sequencer: one glyph row request per cycle, font store writes in order
// ----------------------------------------------------------------------------
module gbb_rowgen (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbb_pkg::t_setup_word i_word,
    input  gbb_pkg::t_cfg        i_cfg,
    output logic                 o_ready,
    output gbb_pkg::t_fetch_req  o_req,
    output gbb_pkg::t_store_wr   o_wr
);
    import gbb_pkg::*;

    logic                    r_active;
    logic [5:0]              r_j;
    logic [5:0]              r_h;
    logic [5:0]              r_w;
    logic [IDX_W-1:0]        r_idx;
    logic [STORE_AW_MAX-1:0] r_base;
    logic [25:0]             r_off;

    logic                    r_req_valid;
    logic [STORE_AW_MAX-1:0] r_req_a0;
    logic [2:0]              r_req_boff;
    logic [5:0]              r_req_w;
    logic [25:0]             r_req_offset;
    logic                    r_req_last;

    logic                    r_wr_en;
    logic [STORE_AW_MAX-1:0] r_wr_addr;
    logic [7:0]              r_wr_data;

    logic w_last;
    logic w_take;
    logic w_start_blit;

    assign w_last       = (r_j == r_h - 6'd1);
    assign o_ready      = !r_active || w_last;
    assign w_take       = i_word.valid && o_ready;
    assign w_start_blit = w_take && (i_word.cmd == CMD_BLIT) && !i_word.drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_req_valid <= 1'b0;
            r_wr_en     <= 1'b0;
        end else begin
            r_req_valid <= r_active;
            r_wr_en     <= w_take && (i_word.cmd == CMD_LOAD);
            if (w_start_blit) begin
                r_active <= 1'b1;
            end else if (r_active && w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // request for the current row
        r_req_a0     <= r_base + STORE_AW_MAX'(r_idx[IDX_W-1:3]);
        r_req_boff   <= r_idx[2:0];
        r_req_w      <= r_w;
        r_req_offset <= r_off;
        r_req_last   <= w_last;

        r_wr_addr <= i_word.addr;
        r_wr_data <= i_word.data;

        if (w_start_blit) begin
            r_j    <= 6'd0;
            r_h    <= i_word.h;
            r_w    <= i_word.w;
            r_idx  <= '0;
            r_base <= i_word.base;
            r_off  <= i_word.offset;
        end else if (r_active) begin
            r_j   <= r_j + 6'd1;
            r_idx <= r_idx + IDX_W'(r_w);
            r_off <= r_off + 26'(i_cfg.line_pitch);
        end
    end

    assign o_req = '{
        valid:   r_req_valid,
        a0:      r_req_a0,
        bit_off: r_req_boff,
        w:       r_req_w,
        offset:  r_req_offset,
        last:    r_req_last
    };

    assign o_wr = '{en: r_wr_en, addr: r_wr_addr, data: r_wr_data};

`ifndef SYNTHESIS
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_j < r_h))
        else $error("row counter past glyph height");

    a_keeps_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !w_last) |=> r_active)
        else $error("glyph ended before its last row");
`endif

endmodule

// ----- design/gbb_fetch.sv -----
// ----------------------------------------------------------------------------
// gbb_fetch
// banked font store, window read and pixel mask extraction
// ----------------------------------------------------------------------------
module gbb_fetch #(
    parameter int FONT_STORE_BYTES = 16384,
    parameter int MAX_GLYPH_SIDE   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbb_pkg::t_fetch_req i_req,
    input  gbb_pkg::t_store_wr  i_wr,
    output logic                o_valid,
    output gbb_pkg::t_out_word  o_result
);
    import gbb_pkg::*;

    localparam int AW   = $clog2(FONT_STORE_BYTES);
    localparam int RW   = AW - 3;
    localparam int ROWS = FONT_STORE_BYTES / NUM_BANKS;
    localparam int NWIN = (MAX_GLYPH_SIDE + 7) / 8 + 1;
    localparam int WW   = 8 * NWIN;

    logic [NUM_BANKS-1:0] w_carry;
    logic [RW-1:0]        w_raddr [NUM_BANKS];
    logic [7:0]           w_rd    [NUM_BANKS];

    logic        r_s1_valid;
    logic [2:0]  r_s1_lo;
    logic [2:0]  r_s1_boff;
    logic [5:0]  r_s1_w;
    logic [25:0] r_s1_offset;
    logic        r_s1_last;

    logic [WW-1:0] w_win;
    logic [WW-1:0] w_shift;
    logic [31:0]   w_mask;

    logic      r_out_valid;
    t_out_word r_out;

    // banks below the first byte's bank hold bytes of the next bank row
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            w_carry[b] = (3'(b) < i_req.a0[2:0]);
            w_raddr[b] = i_req.a0[AW-1:3] + RW'(w_carry[b]);
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [7:0] r_mem [ROWS];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_wr.en && (i_wr.addr[2:0] == 3'(b))) begin
                r_mem[i_wr.addr[AW-1:3]] <= i_wr.data;
            end
            r_rd <= r_mem[w_raddr[b]];
        end

        assign w_rd[b] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_req.valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lo     <= i_req.a0[2:0];
        r_s1_boff   <= i_req.bit_off;
        r_s1_w      <= i_req.w;
        r_s1_offset <= i_req.offset;
        r_s1_last   <= i_req.last;

        r_out.row_offset <= r_s1_offset;
        r_out.row_pixels <= w_mask;
        r_out.last_row   <= r_s1_last;
    end

    // first byte of the row at the top of the window, msb first
    always_comb begin
        w_win = '0;
        for (int k = 0; k < NWIN; k++) begin
            w_win[WW-1-8*k -: 8] = w_rd[3'(r_s1_lo + 3'(k))];
        end
        w_shift = w_win << r_s1_boff;
        w_mask  = '0;
        for (int i = 0; i < MAX_GLYPH_SIDE; i++) begin
            w_mask[i] = (6'(i) < r_s1_w) & w_shift[WW-1-i];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_row_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> r_out_valid)
        else $error("read row lost before output");
`endif

endmodule

// ----- design/glyph_bitmap_blitter.sv -----
// ----------------------------------------------------------------------------
// glyph_bitmap_blitter
// text mode character generator: font store loads and glyph row blits
// ----------------------------------------------------------------------------
// usage
//   command channel: a word is taken on a rising edge with start high and
//   busy low. cmd load writes one font store byte, cmd blit draws a glyph.
//   config channel: i_cfg_valid/o_cfg_ready with a register index and data;
//   ready is always high. write registers only while the block is idle.
//   result channel: o_strobe marks one row word for exactly one cycle; the
//   receiver must take it, there is no back pressure.
// timing
//   a blit passes four setup stages, the row sequencer, the store read and
//   the output register, then its rows come out one row per cycle, so a
//   glyph of h rows gives h row words (up to 32).
//   the row sequencer, one glyph row a cycle, sets the throughput: the next
//   blit enters it on the last row of the previous one. loads and dropped
//   blits are taken by it but start no rows.
// reset
//   synchronous, active low. config returns to 8x16 glyphs, 16 bytes each,
//   256 glyphs, 640x480 screen, 2560 byte pitch. the font store is not
//   cleared and holds garbage until loaded.
// lit pixels mean colour 0xb0b0b0 in the framebuffer, unlit pixels zero
// ----------------------------------------------------------------------------
module glyph_bitmap_blitter #(
    parameter int FONT_STORE_BYTES = 16384,
    parameter int MAX_GLYPH_SIDE   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  gbb_pkg::t_in_word  i_item,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // result channel
    output logic               o_strobe,
    output gbb_pkg::t_out_word o_result
);
    import gbb_pkg::*;

    t_cfg        r_cfg;
    t_setup_word w_setup;
    t_fetch_req  w_req;
    t_store_wr   w_wr;
    logic        w_rowgen_ready;

    // config writes are always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_width   <= RST_GLYPH_WIDTH;
            r_cfg.glyph_height  <= RST_GLYPH_HEIGHT;
            r_cfg.glyph_bytes   <= RST_GLYPH_BYTES;
            r_cfg.glyph_count   <= RST_GLYPH_COUNT;
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.line_pitch    <= RST_LINE_PITCH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GLYPH_WIDTH: begin
                    r_cfg.glyph_width <= i_cfg_data[5:0];
                end
                CFG_GLYPH_HEIGHT: begin
                    r_cfg.glyph_height <= i_cfg_data[5:0];
                end
                CFG_GLYPH_BYTES: begin
                    r_cfg.glyph_bytes <= i_cfg_data[7:0];
                end
                CFG_GLYPH_COUNT: begin
                    r_cfg.glyph_count <= i_cfg_data;
                end
                CFG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data[11:0];
                end
                CFG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data[11:0];
                end
                CFG_LINE_PITCH: begin
                    r_cfg.line_pitch <= i_cfg_data[13:0];
                end
                default: begin
                    // unused index, write is ignored
                end
            endcase
        end
    end

    // glyph select, cell test and first row offset
    gbb_setup #(
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
    ) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_ready (w_rowgen_ready),
        .busy    (busy),
        .o_word  (w_setup)
    );

    // one row per cycle; loads reach the store in item order
    gbb_rowgen u_rowgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (w_setup),
        .i_cfg   (r_cfg),
        .o_ready (w_rowgen_ready),
        .o_req   (w_req),
        .o_wr    (w_wr)
    );

    // banked store read and pixel mask
    gbb_fetch #(
        .FONT_STORE_BYTES (FONT_STORE_BYTES),
        .MAX_GLYPH_SIDE   (MAX_GLYPH_SIDE)
    ) u_fetch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_wr     (w_wr),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

endmodule
